[rtl/discrete_pid_filtered_derivative_assert.svh]
// assertion macros for the pid block, empty when synthesised
`ifndef DISCRETE_PID_FILTERED_DERIVATIVE_ASSERT_SVH
`define DISCRETE_PID_FILTERED_DERIVATIVE_ASSERT_SVH

`ifndef SYNTHESIS

// consequent holds in the cycle after the antecedent
`define DPID_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpid check failed");

// consequent holds in the same cycle as the antecedent
`define DPID_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpid check failed");

`else

`define DPID_ASSERT_NEXT(name, ante, cons)
`define DPID_ASSERT_NOW(name, ante, cons)

`endif

`endif

[rtl/dpid_pkg.sv]
`default_nettype none

package dpid_pkg;

  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [WIDE_W-1:0] RND_HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [WIDE_W-1:0] S32_MAX_W = 64'sd2147483647;
  localparam logic signed [WIDE_W-1:0] S32_MIN_W = -S32_MAX_W - 64'sd1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFERENCE  = 3'd0,
    REG_PROP_GAIN  = 3'd1,
    REG_INT_COEF   = 3'd2,
    REG_DERIV_POLE = 3'd3,
    REG_DERIV_GAIN = 3'd4
  } reg_idx_t;

  // controller state carried from one sample to the next
  typedef struct packed {
    word_t last_error;
    word_t integral_acc;
    word_t deriv_out;
  } state_t;

  typedef struct packed {
    word_t reference;
    word_t prop_gain;
    word_t int_coef;
    word_t deriv_pole;
    word_t deriv_gain;
  } coef_t;

  typedef struct packed {
    logic  clip;
    word_t val;
  } sat_t;

  function automatic wide_t sx(input word_t v);
    return WIDE_W'(v);
  endfunction

  // clip to the signed 32 bit range, flag when clipped
  function automatic sat_t sat32(input wide_t x);
    sat_t r;
    if (x > S32_MAX_W) begin
      r.clip = 1'b1;
      r.val  = S32_MAX_W[DATA_W-1:0];
    end else if (x < S32_MIN_W) begin
      r.clip = 1'b1;
      r.val  = S32_MIN_W[DATA_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // fixed point product, round half up, then arithmetic shift (floor)
  function automatic wide_t fmul(input word_t a, input word_t b);
    wide_t prod;
    prod = sx(a) * sx(b);
    return (prod + RND_HALF) >>> FRAC_BITS;
  endfunction

endpackage

`default_nettype wire

[rtl/dpid_core.sv]
`default_nettype none

// one sample of the controller: error, three terms, saturation and next state
module dpid_core (
  input  var dpid_pkg::coef_t  coef,
  input  var dpid_pkg::state_t state,
  input  var dpid_pkg::word_t  measured,
  input  var logic             clear,
  output var dpid_pkg::state_t state_next,
  output var dpid_pkg::word_t  drive_next,
  output var logic             saturated_next
);
  import dpid_pkg::*;

  sat_t e, p, s, i, diff, d, u;

  always_comb begin
    e    = sat32(sx(coef.reference) - sx(measured));
    p    = sat32(fmul(coef.prop_gain, e.val));
    s    = sat32(sx(e.val) + sx(state.last_error));
    i    = sat32(sx(state.integral_acc) + fmul(coef.int_coef, s.val));
    diff = sat32(sx(e.val) - sx(state.last_error));
    // each product rounded on its own before the add
    d    = sat32(fmul(coef.deriv_pole, state.deriv_out) + fmul(coef.deriv_gain, diff.val));
    u    = sat32(sx(p.val) + sx(i.val) + sx(d.val));

    if (clear) begin
      state_next     = '0;
      drive_next     = '0;
      saturated_next = 1'b0;
    end else begin
      state_next.last_error   = e.val;
      state_next.integral_acc = i.val;
      state_next.deriv_out    = d.val;
      drive_next              = u.val;
      saturated_next          = e.clip | p.clip | s.clip | i.clip | diff.clip | d.clip | u.clip;
    end
  end

endmodule

`default_nettype wire

[rtl/discrete_pid_filtered_derivative.sv]
`default_nettype none

// discrete pid controller with a trapezoidal integrator and a bilinear filtered
// derivative, all signed q16.16 with 32 bit saturation. each beat on the input
// carries one measured sample (or a clear); each gives exactly one result beat
// with the drive value and a flag that is set when the error, a product, an
// internal sum or the output was clipped. a new sample can be taken every
// cycle while the result side does not stall; the sample is held in the input
// register, and the result register takes it from there when free. one
// sample per cycle holds because the state feedback path, which runs the error,
// one 32x32 multiply and the saturating sums, is combinational from the state
// register back to it; a stall on the result side reaches in_stall in the
// same cycle.
// the coefficients are written through the cfg port, indexes 0 to 4 being
// reference, prop_gain, int_coef, deriv_pole and deriv_gain; other indexes are
// ignored. cfg_ready is always high. write them only while the block is idle.
module discrete_pid_filtered_derivative (
  input  var logic                                 clk,
  input  var logic                                 rst,
  input  var logic                                 cfg_valid,
  output var logic                                 cfg_ready,
  input  var logic [dpid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  var logic [dpid_pkg::DATA_W-1:0]          cfg_data,
  input  var logic                                 in_valid,
  output var logic                                 in_stall,
  input  var logic signed [dpid_pkg::DATA_W-1:0]   measured,
  input  var logic                                 clear,
  output var logic                                 out_valid,
  input  var logic                                 out_stall,
  output var logic signed [dpid_pkg::DATA_W-1:0]   drive,
  output var logic                                 saturated
);
  import dpid_pkg::*;

  coef_t  coef;
  state_t state;
  state_t state_next;
  word_t  drive_next;
  logic   saturated_next;

  // input register
  logic   s1_valid;
  word_t  s1_measured;
  logic   s1_clear;

  logic   advance;
  logic   s1_move;

  assign cfg_ready = 1'b1;

  // coefficient registers, out of range indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_REFERENCE:  coef.reference  <= cfg_data;
        REG_PROP_GAIN:  coef.prop_gain  <= cfg_data;
        REG_INT_COEF:   coef.int_coef   <= cfg_data;
        REG_DERIV_POLE: coef.deriv_pole <= cfg_data;
        REG_DERIV_GAIN: coef.deriv_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register frees up when empty or when its beat is taken
  assign advance  = !out_valid || !out_stall;
  assign s1_move  = s1_valid && advance;
  // input register only blocks when its sample cannot move on
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_measured <= measured;
      s1_clear    <= clear;
    end
  end

  dpid_core u_core (
    .coef           (coef),
    .state          (state),
    .measured       (s1_measured),
    .clear          (s1_clear),
    .state_next     (state_next),
    .drive_next     (drive_next),
    .saturated_next (saturated_next)
  );

  // controller state moves with the sample into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_move) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      drive     <= drive_next;
      saturated <= saturated_next;
    end
  end

`include "discrete_pid_filtered_derivative_assert.svh"

  // a clear sample gives a zero, unflagged result
  `DPID_ASSERT_NEXT(a_clear_result, s1_move && s1_clear, out_valid && drive == '0 && !saturated)
  // a clear sample leaves all controller state at zero
  `DPID_ASSERT_NEXT(a_clear_state, s1_move && s1_clear, state == '0)
  // a held sample stays in the input register untouched
  `DPID_ASSERT_NEXT(a_s1_hold, s1_valid && !advance, s1_valid && $stable(s1_measured))
  // state only changes when a sample moves through
  `DPID_ASSERT_NEXT(a_state_quiet, !s1_move, $stable(state))

endmodule

`default_nettype wire

[dv/tb_top.sv]
import dpid_pkg::*;

// predicts the controller output for every accepted sample and checks results in order
class pid_scoreboard;
  typedef logic signed [63:0] acc_t;
  localparam int NUM_COEFS = int'(REG_DERIV_GAIN) + 1;
  localparam acc_t TOP = 64'sd2147483647;
  localparam acc_t BOTTOM = -64'sd2147483648;

  word_t coef [NUM_COEFS];
  acc_t  err_prev;
  acc_t  integ;
  acc_t  deriv;
  word_t drive_q [$];
  logic  clip_q [$];
  int    mismatches;
  int    checked;
  int    samples;
  int    clears;
  int    clipped;
  int    writes;

  function new();
    foreach (coef[k]) coef[k] = '0;
    err_prev = 0;
    integ = 0;
    deriv = 0;
    mismatches = 0;
    checked = 0;
    samples = 0;
    clears = 0;
    clipped = 0;
    writes = 0;
  endfunction

  function acc_t limit32(input acc_t x, inout bit hit);
    if (x > TOP) begin
      hit = 1'b1;
      return TOP;
    end
    if (x < BOTTOM) begin
      hit = 1'b1;
      return BOTTOM;
    end
    return x;
  endfunction

  // exact product, half added, then floor shift
  function acc_t q_mul(input acc_t a, input acc_t b);
    acc_t prod;
    prod = a * b;
    return (prod + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function void set_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
    writes++;
    if (idx <= REG_DERIV_GAIN) coef[idx] = data;
  endfunction

  function int pending();
    return drive_q.size();
  endfunction

  function void note_sample(input word_t meas, input logic clr);
    bit   hit;
    acc_t e;
    acc_t p;
    acc_t s;
    acc_t i;
    acc_t df;
    acc_t d;
    acc_t u;
    samples++;
    if (clr) begin
      clears++;
      err_prev = 0;
      integ = 0;
      deriv = 0;
      drive_q.push_back('0);
      clip_q.push_back(1'b0);
      return;
    end
    hit = 1'b0;
    e = limit32(acc_t'(coef[REG_REFERENCE]) - acc_t'(meas), hit);
    p = limit32(q_mul(coef[REG_PROP_GAIN], e), hit);
    s = limit32(e + err_prev, hit);
    i = limit32(integ + q_mul(coef[REG_INT_COEF], s), hit);
    df = limit32(e - err_prev, hit);
    d = limit32(q_mul(coef[REG_DERIV_POLE], deriv) + q_mul(coef[REG_DERIV_GAIN], df), hit);
    u = limit32(p + i + d, hit);
    err_prev = e;
    integ = i;
    deriv = d;
    if (hit) clipped++;
    drive_q.push_back(word_t'(u));
    clip_q.push_back(hit);
  endfunction

  function void check_drive(input word_t got_drive, input logic got_clip);
    word_t want_drive;
    logic  want_clip;
    if (drive_q.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with nothing expected, drive %0d saturated %0b",
               $time, got_drive, got_clip);
      return;
    end
    want_drive = drive_q.pop_front();
    want_clip = clip_q.pop_front();
    checked++;
    if (got_drive !== want_drive) begin
      mismatches++;
      $display("%0t: drive mismatch, expected %0d (%h) actual %0d (%h)",
               $time, want_drive, want_drive, got_drive, got_drive);
    end
    if (got_clip !== want_clip) begin
      mismatches++;
      $display("%0t: saturated mismatch, expected %0b actual %0b",
               $time, want_clip, got_clip);
    end
  endfunction
endclass

module tb_top;
  // a result passes the input register and then the result register; allow a little slack
  localparam int LATENCY = 1;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_GAP = 30;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BEATS = 75;
  localparam word_t S_MAX = 32'sh7fff_ffff;
  localparam word_t S_MIN = 32'sh8000_0000;
  localparam word_t ONE = 32'sh0001_0000;
  localparam word_t HALF = 32'sh0000_8000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  word_t                measured = '0;
  logic                 clear = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  word_t                drive;
  logic                 saturated;

  pid_scoreboard sb;
  int send_pct = 0;   // chance in a hundred that the sender idles a cycle
  int recv_pct = 0;   // chance in a hundred that the receiver stalls a cycle
  int quiet = 0;

  discrete_pid_filtered_derivative uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .measured  (measured),
    .clear     (clear),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .saturated (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= (recv_pct != 0) && ($urandom_range(0, 99) < recv_pct);
  end

  // every handshake is observed here, so the predictor sees exactly what the block took
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_sample(measured, clear);
      if (out_valid && !out_stall) sb.check_drive(drive, saturated);
    end
  end

  // watchdog: too long without any beat on any channel means the block is stuck
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall)
        || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, quiet, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // one sample beat, with a random idle gap in front of it
  task automatic send_sample(input word_t m, input logic c);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    measured <= m;
    clear <= c;
    do @(posedge clk); while (in_stall);
  endtask

  // drain everything in flight so the coefficients can change safely
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  // writes all five coefficients back to back; optionally also pokes the unused indexes
  task automatic load_coefs(input word_t r, input word_t kp, input word_t ic,
                            input word_t a, input word_t b, input bit unused_too);
    word_t vals [1 << CFG_IDX_W];
    int    last;
    foreach (vals[k]) vals[k] = word_t'($urandom);
    vals[REG_REFERENCE] = r;
    vals[REG_PROP_GAIN] = kp;
    vals[REG_INT_COEF] = ic;
    vals[REG_DERIV_POLE] = a;
    vals[REG_DERIV_GAIN] = b;
    last = unused_too ? (1 << CFG_IDX_W) - 1 : int'(REG_DERIV_GAIN);
    for (int k = 0; k <= last; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly realistic gains within +-4.0, sometimes anything, sometimes an extreme
  function automatic word_t pick_coef();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return word_t'($urandom_range(0, 'h80000) - 'h40000);
    if (sel < 85) return word_t'($urandom);
    case ($urandom_range(0, 3))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return ONE;
    endcase
  endfunction

  // samples mostly near the target so the loop does not sit in saturation
  function automatic word_t pick_sample();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 62) return sb.coef[REG_REFERENCE] + word_t'($urandom_range(0, 'h40000) - 'h20000);
    if (sel < 88) return word_t'($urandom);
    case ($urandom_range(0, 3))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients are all zero: only the error and error difference clips can show
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample('0, 1'b0);
    settle();

    // nominal loop, unused indexes poked as well (they must change nothing)
    load_coefs(ONE, HALF, 32'sh0000_0148, 32'sh0000_e666, 32'sh0000_3333, 1'b1);
    send_sample('0, 1'b0);
    send_sample(HALF, 1'b0);
    send_sample(HALF, 1'b0);
    send_sample(ONE, 1'b0);
    send_sample(S_MAX, 1'b1);   // clear mid-run
    send_sample(-ONE, 1'b0);
    settle();

    // rounding ties: +0.5 lsb rounds up, -0.5 lsb rounds toward zero
    load_coefs('0, HALF, '0, '0, '0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd3, 1'b0);
    settle();

    // largest positive everything: error, sums and output all clip
    load_coefs(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample('0, 1'b0);
    settle();

    // most negative everything
    load_coefs(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample('0, 1'b1);
    settle();

    // random phases, cycling through the idling modes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          send_pct = 0;
          recv_pct = 0;
        end
        1: begin
          send_pct = 62;
          recv_pct = 0;
        end
        2: begin
          send_pct = 0;
          recv_pct = 62;
        end
        default: begin
          send_pct = 29;
          recv_pct = 29;
        end
      endcase
      load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                 ($urandom_range(0, 3) == 0));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_sample(pick_sample(), ($urandom_range(0, 99) < 4));
      end
      settle();
    end

    $display("covered %0d samples (%0d clears, %0d clipped) over %0d register writes",
             sb.samples, sb.clears, sb.clipped, sb.writes);
    $display("%0d results checked, %0d mismatches, %0d left outstanding",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/dpid_pkg.sv
rtl/dpid_core.sv
rtl/discrete_pid_filtered_derivative.sv
dv/tb_top.sv
